// File: hdl/clp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

    localparam int CLP_PORT_BITS  = 8;
    localparam int CLP_MAX_PINS   = 8;
    localparam int CLP_MAX_LEDS   = 56;
    localparam int CLP_SLOT_TICKS = 16;
    localparam int CLP_DUTY_MAX   = 16;
    localparam int CLP_DUTY_W     = 5;
    localparam int CLP_LED_W      = 6;
    localparam int CLP_PIN_W      = 3;
    localparam int CLP_NPIN_W     = 4;
    localparam int CLP_TABLE_SIZE = 256;

    localparam logic [1:0] CLP_OP_TICK  = 2'd0;
    localparam logic [1:0] CLP_OP_SET   = 2'd1;
    localparam logic [1:0] CLP_OP_CLEAR = 2'd2;

    localparam logic [1:0] CLP_REG_FIRST_PIN = 2'd0;
    localparam logic [1:0] CLP_REG_PINS      = 2'd1;

    typedef logic [CLP_PORT_BITS-1:0] t_port;

    typedef struct packed {
        logic                 found;
        logic [CLP_PIN_W-1:0] lo;
        logic [CLP_PIN_W-1:0] hi;
    } t_pair;

    typedef t_pair [CLP_TABLE_SIZE-1:0] t_pair_table;

    typedef struct packed {
        t_port                dir;
        t_port                val;
        logic [CLP_LED_W-1:0] led;
    } t_result;

    // index is {pin count - 2, pair number}
    function automatic t_pair_table clp_build_pairs();
        t_pair_table tbl;
        int          k;
        int          idx;
        tbl = '0;
        for (int p = 2; p <= CLP_MAX_PINS; p++) begin
            k = 0;
            for (int i = 0; i < p; i++) begin
                for (int j = i + 1; j < p; j++) begin
                    idx = (p - 2) * 32 + k;
                    tbl[idx].found = 1'b1;
                    tbl[idx].lo    = CLP_PIN_W'(i);
                    tbl[idx].hi    = CLP_PIN_W'(j);
                    k++;
                end
            end
        end
        return tbl;
    endfunction

    localparam t_pair_table CLP_PAIR_TABLE = clp_build_pairs();

    function automatic logic [CLP_LED_W-1:0] clp_led_count(input logic [CLP_NPIN_W-1:0] pins);
        logic [7:0] prod;
        prod = {4'b0, pins} * ({4'b0, pins} - 8'd1);
        return prod[CLP_LED_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/clp_led_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module clp_led_decode
    import clp_pkg::*;
(
    input  wire logic [CLP_LED_W-1:0] i_led,
    input  wire logic [2:0]           i_pin_code,
    input  wire logic [CLP_PIN_W-1:0] i_first_pin,
    output t_port                     o_dir,
    output t_port                     o_val
);

    t_pair      pair;
    logic [3:0] pos_lo;
    logic [3:0] pos_hi;
    t_port      bit_lo;
    t_port      bit_hi;

    always_comb begin
        pair   = CLP_PAIR_TABLE[{i_pin_code, i_led[CLP_LED_W-1:1]}];
        pos_lo = {1'b0, i_first_pin} + {1'b0, pair.lo};
        pos_hi = {1'b0, i_first_pin} + {1'b0, pair.hi};
        bit_lo = (pos_lo < 4'(CLP_PORT_BITS)) ? (t_port'(1) << pos_lo) : '0;
        bit_hi = (pos_hi < 4'(CLP_PORT_BITS)) ? (t_port'(1) << pos_hi) : '0;
        if (pair.found) begin
            o_dir = bit_lo | bit_hi;
            o_val = i_led[0] ? bit_hi : bit_lo;
        end else begin
            o_dir = '0;
            o_val = '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/clp_duty_store.sv
`timescale 1ns / 1ps
`default_nettype none

module clp_duty_store
    import clp_pkg::*;
#(
    parameter int DEPTH = CLP_MAX_LEDS,
    parameter int AW    = $clog2(CLP_MAX_LEDS)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire logic [CLP_DUTY_W-1:0] i_wr_data,
    input  wire logic                  i_clear,
    input  wire logic [AW-1:0]         i_rd_addr,
    output logic      [CLP_DUTY_W-1:0] o_rd_data
);

    logic [CLP_DUTY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]      r_valid;
    logic [DEPTH-1:0]      n_valid;
    logic [CLP_DUTY_W-1:0] r_rd_data;
    logic                  r_rd_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = '0;
        end else if (i_wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_rd_valid <= n_valid[i_rd_addr];
        end
    end

    // write-first: a same-cycle write to the read address is forwarded
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= (i_wr_en && (i_wr_addr == i_rd_addr)) ? i_wr_data : r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: hdl/clp_result_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module clp_result_skid
    import clp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_result      o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop = r_main_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (pop && r_skid_valid) begin
            r_main <= r_skid;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_main_valid;
    assign o_data      = r_main;

endmodule

`default_nettype wire

// File: hdl/charlieplex_led_pwm_scanner.sv
`timescale 1ns / 1ps
`default_nettype none

// Charlieplexed LED PWM scanner.
// Input channel (i_in_valid / o_in_ready) carries one item: a tick, a
// set of one LED duty, or a clear of all duties. Every accepted item gives
// one result on the output channel (o_out_valid / i_out_ready): port
// direction bits, port value bits and the LED owning the scan slot.
// Each result is registered into the output buffer; one item is accepted
// every cycle while that buffer is not full. The duty of the next LED in the
// scan is read ahead from the duty memory, so it is ready at a slot change.
// A two-entry result buffer sits on the output: when the receiver stalls,
// one more item is accepted and o_in_ready then drops until a result is
// taken. Results are never dropped.
// Configuration writes (i_cfg_write, i_cfg_index, i_cfg_data) take effect
// at once, blank the port and restart the scan at LED 0; duties are kept.
// Synchronous reset clears all duties, blanks the port, sets the first
// pin to 0 and the pin count to 8, and empties the result buffer.
module charlieplex_led_pwm_scanner
    import clp_pkg::*;
#(
    parameter int MAX_LEDS   = CLP_MAX_LEDS,
    parameter int SLOT_TICKS = CLP_SLOT_TICKS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_operation,
    input  wire logic [CLP_LED_W-1:0]  i_led_index,
    input  wire logic [CLP_DUTY_W-1:0] i_duty,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CLP_PORT_BITS-1:0]   o_port_direction,
    output logic [CLP_PORT_BITS-1:0]   o_port_value,
    output logic [CLP_LED_W-1:0]       o_active_led,
    input  wire logic                  i_cfg_write,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CLP_NPIN_W-1:0] i_cfg_data
);

    localparam int AW         = $clog2(MAX_LEDS);
    localparam int TICK_W     = $clog2(SLOT_TICKS);
    localparam int CNT_W      = $clog2(SLOT_TICKS + 1);
    localparam int CMP_W      = (CNT_W > CLP_DUTY_W) ? CNT_W : CLP_DUTY_W;
    localparam int DUTY_LIMIT = (CLP_DUTY_MAX < SLOT_TICKS) ? CLP_DUTY_MAX : SLOT_TICKS;

    logic [CLP_PIN_W-1:0]  r_first_pin, n_first_pin;
    logic [CLP_NPIN_W-1:0] r_pins, n_pins;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [CLP_LED_W-1:0]  r_led, n_led;
    logic [CLP_DUTY_W-1:0] r_cur_duty, n_cur_duty;
    t_port                 r_dir, n_dir;
    t_port                 r_val, n_val;

    logic                  accept;
    logic                  buf_full;
    logic [CLP_NPIN_W-1:0] pin_count;
    logic [2:0]            pin_code;
    logic [CLP_LED_W-1:0]  count_raw;
    logic [CLP_LED_W-1:0]  led_count;
    logic [CLP_LED_W:0]    led_inc;
    logic [CLP_LED_W-1:0]  next_led;
    t_port                 cur_dir, cur_val;
    t_port                 nxt_dir, nxt_val;
    logic [CLP_DUTY_W-1:0] next_duty;
    logic [CLP_DUTY_W-1:0] sat_duty;
    logic [CNT_W-1:0]      tick_inc;
    logic                  release_hit;
    logic                  slot_end;
    logic                  duty_wr;
    logic                  duty_clr;
    t_result               result;
    t_result               out_data;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !buf_full;

    always_comb begin
        if (r_pins < 4'd2) begin
            pin_count = 4'd2;
        end else if (r_pins > 4'(CLP_PORT_BITS)) begin
            pin_count = 4'(CLP_PORT_BITS);
        end else begin
            pin_count = r_pins;
        end
        pin_code  = 3'(pin_count - 4'd2);
        count_raw = clp_led_count(pin_count);
        led_count = (count_raw > CLP_LED_W'(MAX_LEDS)) ? CLP_LED_W'(MAX_LEDS) : count_raw;
        led_inc   = {1'b0, r_led} + 7'd1;
        next_led  = (led_inc >= {1'b0, led_count}) ? '0 : led_inc[CLP_LED_W-1:0];
        sat_duty  = (i_duty > CLP_DUTY_W'(DUTY_LIMIT)) ? CLP_DUTY_W'(DUTY_LIMIT) : i_duty;
    end

    clp_led_decode u_cur_decode (
        .i_led       (r_led),
        .i_pin_code  (pin_code),
        .i_first_pin (r_first_pin),
        .o_dir       (cur_dir),
        .o_val       (cur_val)
    );

    clp_led_decode u_nxt_decode (
        .i_led       (next_led),
        .i_pin_code  (pin_code),
        .i_first_pin (r_first_pin),
        .o_dir       (nxt_dir),
        .o_val       (nxt_val)
    );

    clp_duty_store #(
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_duty_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (duty_wr),
        .i_wr_addr (i_led_index[AW-1:0]),
        .i_wr_data (sat_duty),
        .i_clear   (duty_clr),
        .i_rd_addr (next_led[AW-1:0]),
        .o_rd_data (next_duty)
    );

    always_comb begin
        n_first_pin = r_first_pin;
        n_pins      = r_pins;
        n_tick      = r_tick;
        n_led       = r_led;
        n_cur_duty  = r_cur_duty;
        n_dir       = r_dir;
        n_val       = r_val;
        duty_wr     = 1'b0;
        duty_clr    = 1'b0;
        tick_inc    = CNT_W'(r_tick) + CNT_W'(1);
        release_hit = (CMP_W'(r_cur_duty) == CMP_W'(tick_inc));
        slot_end    = (tick_inc >= CNT_W'(SLOT_TICKS));
        if (i_cfg_write && (i_cfg_index == CLP_REG_FIRST_PIN || i_cfg_index == CLP_REG_PINS)) begin
            if (i_cfg_index == CLP_REG_FIRST_PIN) begin
                n_first_pin = i_cfg_data[CLP_PIN_W-1:0];
            end else begin
                n_pins = i_cfg_data;
            end
            n_tick     = '0;
            n_led      = '0;
            n_cur_duty = '0;
            n_dir      = '0;
            n_val      = '0;
        end else if (accept) begin
            case (i_operation)
                CLP_OP_TICK: begin
                    if (release_hit) begin
                        n_dir = n_dir & ~cur_dir;
                        n_val = n_val & ~cur_val;
                    end
                    if (slot_end) begin
                        n_tick     = '0;
                        n_led      = next_led;
                        n_cur_duty = next_duty;
                        if (next_duty != '0) begin
                            n_dir = n_dir | nxt_dir;
                            n_val = n_val | nxt_val;
                        end
                    end else begin
                        n_tick = TICK_W'(tick_inc);
                    end
                end
                CLP_OP_SET: begin
                    duty_wr = (i_led_index < led_count);
                end
                CLP_OP_CLEAR: begin
                    duty_clr = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pin <= '0;
            r_pins      <= 4'd8;
            r_tick      <= '0;
            r_led       <= '0;
            r_cur_duty  <= '0;
            r_dir       <= '0;
            r_val       <= '0;
        end else begin
            r_first_pin <= n_first_pin;
            r_pins      <= n_pins;
            r_tick      <= n_tick;
            r_led       <= n_led;
            r_cur_duty  <= n_cur_duty;
            r_dir       <= n_dir;
            r_val       <= n_val;
        end
    end

    assign result.dir = n_dir;
    assign result.val = n_val;
    assign result.led = n_led;

    clp_result_skid u_result_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (result),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (out_data)
    );

    assign o_port_direction = out_data.dir;
    assign o_port_value     = out_data.val;
    assign o_active_led     = out_data.led;

    a_val_within_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_val & ~r_dir) == '0)
        else $error("driven-high bit without output enable");

    a_one_led_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_dir) <= 2 && $countones(r_val) <= 1)
        else $error("more than one LED driven");

    a_led_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led < led_count)
        else $error("scan LED beyond LED count");

    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_tick) < CNT_W'(SLOT_TICKS))
        else $error("tick count past slot length");

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

endmodule

`default_nettype wire

// File: tb/clp_checker.sv
`timescale 1ns / 1ps

module clp_checker
    import clp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic [1:0]            i_operation,
    input  wire logic [CLP_LED_W-1:0]  i_led_index,
    input  wire logic [CLP_DUTY_W-1:0] i_duty,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [CLP_PORT_BITS-1:0] i_port_direction,
    input  wire logic [CLP_PORT_BITS-1:0] i_port_value,
    input  wire logic [CLP_LED_W-1:0]  i_active_led,
    input  wire logic                  i_cfg_write,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CLP_NPIN_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_errors,
    output int                         o_checked
);

    logic [CLP_PIN_W-1:0]  first_pin_q;
    logic [CLP_NPIN_W-1:0] pin_setting_q;
    logic [CLP_DUTY_W-1:0] duty_mem [CLP_MAX_LEDS];
    logic [CLP_DUTY_W-1:0] tick_q;
    logic [CLP_LED_W-1:0]  scan_led_q;
    logic [CLP_DUTY_W-1:0] held_duty_q;
    t_port                 drive_en_q;
    t_port                 drive_hi_q;
    t_result               port_states_q[$];
    int                    error_count = 0;
    int                    compared_count = 0;

    function automatic int active_pins();
        int p;
        p = int'(pin_setting_q);
        if (p < 2) p = 2;
        if (p > CLP_PORT_BITS) p = CLP_PORT_BITS;
        return p;
    endfunction

    function automatic int active_leds();
        int n;
        n = active_pins() * (active_pins() - 1);
        if (n > CLP_MAX_LEDS) n = CLP_MAX_LEDS;
        return n;
    endfunction

    function automatic t_port pin_line(input int pin);
        int pos;
        pos = int'(first_pin_q) + pin;
        if (pos >= CLP_PORT_BITS) return '0;
        return t_port'(1) << pos;
    endfunction

    // LEDs come in pin pairs (a<b): even number drives a high, odd drives b high
    function automatic void led_lines(input int led, output t_port en, output t_port hi);
        int k;
        int p;
        en = '0;
        hi = '0;
        k  = 0;
        p  = active_pins();
        for (int a = 0; a < p; a++) begin
            for (int b = a + 1; b < p; b++) begin
                if (k == led || k + 1 == led) begin
                    en = pin_line(a) | pin_line(b);
                    hi = (k == led) ? pin_line(a) : pin_line(b);
                    return;
                end
                k += 2;
            end
        end
    endfunction

    function automatic void restart_scan();
        tick_q      = '0;
        scan_led_q  = '0;
        held_duty_q = '0;
        drive_en_q  = '0;
        drive_hi_q  = '0;
    endfunction

    function automatic void advance_tick();
        t_port en;
        t_port hi;
        tick_q = tick_q + 1'b1;
        if (held_duty_q == tick_q) begin
            led_lines(int'(scan_led_q), en, hi);
            drive_en_q &= ~en;
            drive_hi_q &= ~hi;
        end
        if (tick_q >= CLP_SLOT_TICKS) begin
            tick_q = '0;
            if (int'(scan_led_q) + 1 >= active_leds()) scan_led_q = '0;
            else scan_led_q = scan_led_q + 1'b1;
            held_duty_q = duty_mem[scan_led_q];
            if (held_duty_q != '0) begin
                led_lines(int'(scan_led_q), en, hi);
                drive_en_q |= en;
                drive_hi_q |= hi;
            end
        end
    endfunction

    function automatic void flag_field(input string field, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result nxt;
        if (!i_rst_n) begin
            first_pin_q   = '0;
            pin_setting_q = 4'd8;
            foreach (duty_mem[n]) duty_mem[n] = '0;
            restart_scan();
            port_states_q.delete();
        end else begin
            if (i_cfg_write) begin
                case (i_cfg_index)
                    CLP_REG_FIRST_PIN: begin
                        first_pin_q = i_cfg_data[CLP_PIN_W-1:0];
                        restart_scan();
                    end
                    CLP_REG_PINS: begin
                        pin_setting_q = i_cfg_data;
                        restart_scan();
                    end
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (port_states_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result dir %0d val %0d led %0d", $time,
                             i_port_direction, i_port_value, i_active_led);
                end else begin
                    want = port_states_q.pop_front();
                    flag_field("port_direction", int'(want.dir), int'(i_port_direction));
                    flag_field("port_value", int'(want.val), int'(i_port_value));
                    flag_field("active_led", int'(want.led), int'(i_active_led));
                    compared_count++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_operation)
                    CLP_OP_TICK: advance_tick();
                    CLP_OP_SET: begin
                        if (int'(i_led_index) < active_leds())
                            duty_mem[i_led_index] = (i_duty > CLP_DUTY_MAX) ?
                                CLP_DUTY_W'(CLP_DUTY_MAX) : i_duty;
                    end
                    CLP_OP_CLEAR: foreach (duty_mem[n]) duty_mem[n] = '0;
                    default: ;
                endcase
                nxt.dir = drive_en_q;
                nxt.val = drive_hi_q;
                nxt.led = scan_led_q;
                port_states_q.push_back(nxt);
            end
        end
        o_pending <= port_states_q.size();
        o_errors  <= error_count;
        o_checked <= compared_count;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import clp_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         NUM_SETTINGS = 8;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_operation = '0;
    logic [CLP_LED_W-1:0]    i_led_index = '0;
    logic [CLP_DUTY_W-1:0]   i_duty = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [CLP_PORT_BITS-1:0] o_port_direction;
    logic [CLP_PORT_BITS-1:0] o_port_value;
    logic [CLP_LED_W-1:0]    o_active_led;
    logic                    i_cfg_write = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [CLP_NPIN_W-1:0]   i_cfg_data = '0;

    int pending;
    int errors;
    int checked;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int stim_pins = 8;

    // pin settings per phase: {first pin data, pin count data}
    logic [CLP_NPIN_W-1:0] setting_first [NUM_SETTINGS] = '{4'd0, 4'd15, 4'd3, 4'd2,
                                                            4'd0, 4'd5, 4'd6, 4'd1};
    logic [CLP_NPIN_W-1:0] setting_pins [NUM_SETTINGS]  = '{4'd2, 4'd3, 4'd0, 4'd15,
                                                            4'd8, 4'd4, 4'd1, 4'd6};

    always #5 i_clk = ~i_clk;

    charlieplex_led_pwm_scanner i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_led_index     (i_led_index),
        .i_duty          (i_duty),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_port_direction(o_port_direction),
        .o_port_value    (o_port_value),
        .o_active_led    (o_active_led),
        .i_cfg_write     (i_cfg_write),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    clp_checker scan_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_led_index     (i_led_index),
        .i_duty          (i_duty),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_port_direction(o_port_direction),
        .i_port_value    (o_port_value),
        .i_active_led    (o_active_led),
        .i_cfg_write     (i_cfg_write),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_errors        (errors),
        .o_checked       (checked)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic int stim_leds();
        int p;
        p = stim_pins;
        if (p < 2) p = 2;
        if (p > CLP_PORT_BITS) p = CLP_PORT_BITS;
        p = p * (p - 1);
        return (p > CLP_MAX_LEDS) ? CLP_MAX_LEDS : p;
    endfunction

    task automatic send(input logic [1:0] op, input int idx, input int d);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_led_index <= CLP_LED_W'(idx);
        i_duty      <= CLP_DUTY_W'(d);
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CLP_NPIN_W-1:0] data);
        i_cfg_write <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_write <= 1'b0;
        @(posedge i_clk);
        if (idx == CLP_REG_PINS) stim_pins = int'(data);
    endtask

    initial begin : stimulus
        int r;
        int n_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out-of-range sets, saturation, unused op, then one full slot and a clear
        send(CLP_OP_SET, 1, 1);
        send(CLP_OP_SET, 55, 31);
        send(CLP_OP_SET, 56, 9);
        send(CLP_OP_SET, 63, 31);
        send(OP_UNUSED, 63, 31);
        send(CLP_OP_SET, 0, 16);
        repeat (17) send(CLP_OP_TICK, 0, 0);
        send(CLP_OP_CLEAR, 42, 21);

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            drain();
            write_reg(CLP_REG_FIRST_PIN, setting_first[ph]);
            write_reg(CLP_REG_PINS, setting_pins[ph]);
            if (ph == 2) write_reg(REG_SPARE_A, 4'd5);
            if (ph == 5) write_reg(REG_SPARE_B, 4'd10);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 73; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            n_items = (stim_leds() <= 6) ? 60 : 35;
            for (int k = 0; k < n_items; k++) begin
                r = $urandom_range(99);
                if (r < 68)
                    send(CLP_OP_TICK, $urandom_range(63), $urandom_range(31));
                else if (r < 88)
                    send(CLP_OP_SET, $urandom_range(stim_leds() - 1),
                         ($urandom_range(4) == 0) ? $urandom_range(17, 31) : $urandom_range(16));
                else if (r < 93)
                    send(CLP_OP_SET, $urandom_range(stim_leds(), 63), $urandom_range(31));
                else if (r < 96)
                    send(CLP_OP_CLEAR, $urandom_range(63), $urandom_range(31));
                else
                    send(OP_UNUSED, $urandom_range(63), $urandom_range(31));
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        $display("sent %0d items over %0d pin settings with mixed idle and stall;",
                 items_sent, NUM_SETTINGS + 1);
        $display("%0d results checked", checked);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
